// File: rtl/sppb_pkg.sv
// Package for the stack push/pop bus sequencer: types, step codes and constants.
package sppb_pkg;

	// Sequencer steps, push (U) and pop (O) flows
	typedef enum logic [4:0] {
		ST_IDLE   = 5'd0,
		ST_U_T4   = 5'd1,
		ST_U_T5   = 5'd2,
		ST_U_M2T1 = 5'd3,
		ST_U_M2T2 = 5'd4,
		ST_U_M2T3 = 5'd5,
		ST_U_M3T1 = 5'd6,
		ST_U_M3T2 = 5'd7,
		ST_U_M3T3 = 5'd8,
		ST_O_T4   = 5'd9,
		ST_O_M2T1 = 5'd10,
		ST_O_M2T2 = 5'd11,
		ST_O_M2TW = 5'd12,
		ST_O_M2T3 = 5'd13,
		ST_O_M3T1 = 5'd14,
		ST_O_M3T2 = 5'd15,
		ST_O_M3TW = 5'd16,
		ST_O_M3T3 = 5'd17
	} step_t;

	// Clock phase event codes
	localparam logic [1:0] PH_ONE_RISE = 2'd0;
	localparam logic [1:0] PH_TWO_RISE = 2'd1;
	localparam logic [1:0] PH_TWO_FALL = 2'd2;

	// Input word kinds
	localparam logic MODE_START = 1'b0;

	// Opcode decode
	localparam logic [7:0] OP_KIND_MASK = 8'hCF;
	localparam logic [7:0] OP_KIND_PUSH = 8'hC5;
	localparam logic [7:0] OP_KIND_POP  = 8'hC1;
	localparam logic [1:0] PAIR_PSW     = 2'd3;
	localparam logic [7:0] PSW_SET      = 8'h02;
	localparam logic [7:0] PSW_CLR      = 8'h28;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_STATUS_WRITE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STATUS_READ  = 8'd1;
	localparam logic [7:0] STATUS_WRITE_RST = 8'h04;
	localparam logic [7:0] STATUS_READ_RST  = 8'h86;

	// Stream widths
	localparam int unsigned IN_DATA_W  = 56;
	localparam int unsigned OUT_DATA_W = 64;

	typedef struct packed {
		logic       mode;
		logic [7:0] opcode;
		logic [15:0] sp_in;
		logic [7:0] push_high;
		logic [7:0] push_low;
		logic [1:0] phase;
		logic       ready_req;
		logic [7:0] data_in;
	} item_t;

	typedef struct packed {
		step_t       step;
		logic        op_is_pop;
		logic [1:0]  pair_sel;
		logic [15:0] sp;
		logic [15:0] addr_latch;
		logic [7:0]  held_high;
		logic [7:0]  held_low;
		logic [15:0] bus_address;
		logic [7:0]  bus_data;
		logic        addr_on;
		logic        data_on;
		logic        sync;
		logic        dbin;
		logic        wr_n;
		logic        wait_line;
	} seq_state_t;

	typedef struct packed {
		logic [15:0] address;
		logic        address_driven;
		logic [7:0]  data_out;
		logic        data_driven;
		logic        sync;
		logic        dbin;
		logic        write_n;
		logic        wait_flag;
		logic        done_res;
		logic [15:0] sp_out;
		logic [7:0]  pop_high;
		logic [7:0]  pop_low;
	} result_t;

	localparam seq_state_t SEQ_STATE_RST = '{
		step: ST_IDLE, op_is_pop: 1'b0, pair_sel: 2'd0, sp: 16'd0, addr_latch: 16'd0,
		held_high: 8'd0, held_low: 8'd0, bus_address: 16'd0, bus_data: 8'd0,
		addr_on: 1'b0, data_on: 1'b0, sync: 1'b0, dbin: 1'b0, wr_n: 1'b1,
		wait_line: 1'b0
	};

endpackage

// File: rtl/sppb_step.sv
// Next-state and bus result logic for one input word of the sequencer.
module sppb_step import sppb_pkg::*; (
	input  seq_state_t st,
	input  item_t      item,
	input  logic [7:0] status_write,
	input  logic [7:0] status_read,
	output seq_state_t nxt,
	output result_t    res
);

	logic [7:0] kind;
	logic       done;

	assign kind = item.opcode & OP_KIND_MASK;

	// Next state
	always_comb begin
		nxt  = st;
		done = 1'b0;
		if (item.mode == MODE_START) begin
			if (kind == OP_KIND_PUSH || kind == OP_KIND_POP) begin
				nxt.op_is_pop = (kind == OP_KIND_POP);
				nxt.pair_sel  = item.opcode[5:4];
				nxt.sp        = item.sp_in;
				if (kind == OP_KIND_POP) begin
					nxt.held_high = 8'd0;
					nxt.held_low  = 8'd0;
					nxt.step      = ST_O_T4;
				end else begin
					nxt.held_high = item.push_high;
					nxt.held_low  = item.push_low;
					nxt.step      = ST_U_T4;
				end
			end
		end else begin
			done = (st.step == ST_U_M3T3) || (st.step == ST_O_M3T3);
			case (item.phase)
				PH_ONE_RISE: begin
					if (st.step == ST_U_M2T3 || st.step == ST_U_M3T3) begin
						nxt.wr_n = 1'b0;
					end else if (st.step == ST_O_M2TW || st.step == ST_O_M3TW) begin
						nxt.wait_line = 1'b1;
					end else if (st.step == ST_O_M2T3 || st.step == ST_O_M3T3) begin
						nxt.wait_line = 1'b0;
					end
				end
				PH_TWO_RISE: begin
					unique case (st.step)
						ST_U_T4: nxt.addr_latch = st.sp;
						ST_U_T5: nxt.sp = st.addr_latch - 16'd1;
						ST_U_M2T1, ST_U_M3T1, ST_O_M2T1, ST_O_M3T1: begin
							// T1: latch SP, drive address and status
							nxt.addr_latch  = st.sp;
							nxt.bus_address = st.sp;
							nxt.addr_on     = 1'b1;
							nxt.bus_data    = st.step inside {ST_U_M2T1, ST_U_M3T1}
								? status_write : status_read;
							nxt.data_on     = 1'b1;
							nxt.sync        = 1'b1;
						end
						ST_U_M2T2: begin
							nxt.sp       = st.addr_latch - 16'd1;
							nxt.sync     = 1'b0;
							nxt.bus_data = st.held_high;
						end
						ST_U_M3T2: begin
							nxt.sync     = 1'b0;
							nxt.bus_data = st.held_low;
						end
						ST_O_M2T2, ST_O_M3T2: begin
							nxt.data_on = 1'b0;
							nxt.sync    = 1'b0;
							nxt.dbin    = 1'b1;
							nxt.sp      = st.addr_latch + 16'd1;
						end
						ST_O_M2TW, ST_O_M3TW: nxt.dbin = 1'b1;
						ST_O_M2T3: begin
							// POP PSW: bit 1 set, bits 3 and 5 cleared
							nxt.held_low = (st.pair_sel == PAIR_PSW)
								? ((item.data_in | PSW_SET) & ~PSW_CLR) : item.data_in;
							nxt.dbin     = 1'b0;
							nxt.addr_on  = 1'b0;
						end
						ST_O_M3T3: begin
							nxt.held_high = item.data_in;
							nxt.dbin      = 1'b0;
							nxt.addr_on   = 1'b0;
						end
						default: ;
					endcase
				end
				PH_TWO_FALL: begin
					unique case (st.step)
						ST_U_M2T3: begin
							nxt.wr_n    = 1'b1;
							nxt.addr_on = 1'b0;
							nxt.step    = ST_U_M3T1;
						end
						ST_U_M3T3: begin
							nxt.wr_n    = 1'b1;
							nxt.addr_on = 1'b0;
							nxt.step    = ST_IDLE;
						end
						ST_U_T4:   nxt.step = ST_U_T5;
						ST_U_T5:   nxt.step = ST_U_M2T1;
						ST_U_M2T1: nxt.step = ST_U_M2T2;
						ST_U_M2T2: nxt.step = ST_U_M2T3;
						ST_U_M3T1: nxt.step = ST_U_M3T2;
						ST_U_M3T2: nxt.step = ST_U_M3T3;
						ST_O_T4:   nxt.step = ST_O_M2T1;
						ST_O_M2T1: nxt.step = ST_O_M2T2;
						ST_O_M3T1: nxt.step = ST_O_M3T2;
						ST_O_M2T2, ST_O_M2TW:
							nxt.step = item.ready_req ? ST_O_M2T3 : ST_O_M2TW;
						ST_O_M3T2, ST_O_M3TW:
							nxt.step = item.ready_req ? ST_O_M3T3 : ST_O_M3TW;
						ST_O_M2T3: nxt.step = ST_O_M3T1;
						ST_O_M3T3: nxt.step = ST_IDLE;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Bus view after the word
	always_comb begin
		res.address        = nxt.addr_on ? nxt.bus_address : 16'd0;
		res.address_driven = nxt.addr_on;
		res.data_out       = nxt.data_on ? nxt.bus_data : 8'd0;
		res.data_driven    = nxt.data_on;
		res.sync           = nxt.sync;
		res.dbin           = nxt.dbin;
		res.write_n        = nxt.wr_n;
		res.wait_flag      = nxt.wait_line;
		res.done_res       = done;
		res.sp_out         = nxt.sp;
		res.pop_high       = nxt.op_is_pop ? nxt.held_high : 8'd0;
		res.pop_low        = nxt.op_is_pop ? nxt.held_low : 8'd0;
	end

endmodule

// File: rtl/stack_push_pop_bus_sequencer_unit.sv
// Top level: 8080 PUSH/POP stack bus sequencer with stream ports and config port.
// Each accepted word passes the input register and then the result register.
// Throughput: one word per cycle; input register, step logic and result register
// form a single pass, so back-to-back words run at full rate under no stall.
// Reset (arst_n low, asynchronous): sequencer idle, SP and latches zero, buses
// released with write_n high, status registers at 0x04 (write) and 0x86 (read).
module stack_push_pop_bus_sequencer_unit import sppb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata: opcode[7:0], sp_in[23:8], push_high[31:24], push_low[39:32],
	//        phase[41:40], ready_req[42], data_in[50:43], zero fill[55:51]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: mode[0]
	input  logic [0:0]            s_axis_tuser,
	// Output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata: address[15:0], address_driven[16], data_out[24:17], data_driven[25],
	//        sync[26], dbin[27], write_n[28], wait_flag[29], sp_out[45:30],
	//        pop_high[53:46], pop_low[61:54], zero fill[63:62]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// tlast: done_res
	output logic                  m_axis_tlast,
	// Configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]            cfg_data
);

	logic       valid_s1;
	item_t      item_s1;
	logic       out_valid_q;
	result_t    result_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	result_t    result_nxt;
	logic [7:0] status_write_q;
	logic [7:0] status_read_q;
	logic       adv;

	// Word in the input register moves on when the result register frees up
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign cfg_ready     = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.mode      <= s_axis_tuser[0];
			item_s1.opcode    <= s_axis_tdata[7:0];
			item_s1.sp_in     <= s_axis_tdata[23:8];
			item_s1.push_high <= s_axis_tdata[31:24];
			item_s1.push_low  <= s_axis_tdata[39:32];
			item_s1.phase     <= s_axis_tdata[41:40];
			item_s1.ready_req <= s_axis_tdata[42];
			item_s1.data_in   <= s_axis_tdata[50:43];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_write_q <= STATUS_WRITE_RST;
			status_read_q  <= STATUS_READ_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_STATUS_WRITE: status_write_q <= cfg_data;
				CFG_STATUS_READ:  status_read_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step logic
	sppb_step u_step (
		.st           (state_q),
		.item         (item_s1),
		.status_write (status_write_q),
		.status_read  (status_read_q),
		.nxt          (state_nxt),
		.res          (result_nxt)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_STATE_RST;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= result_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = result_q.done_res;
	assign m_axis_tdata  = {2'b00, result_q.pop_low, result_q.pop_high, result_q.sp_out,
		result_q.wait_flag, result_q.write_n, result_q.dbin, result_q.sync,
		result_q.data_driven, result_q.data_out, result_q.address_driven,
		result_q.address};

	// A word leaving the input register always lands in the result register
	a_adv_loads: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result register not loaded after advance");

	// A held input word blocks new words
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |-> !s_axis_tready)
		else $error("input accepted while input register held");

	// Shown stack pointer matches the sequencer state it came from
	a_sp_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (result_q.sp_out == state_q.sp))
		else $error("result stack pointer differs from state");

endmodule

// File: tb/sppb_bus_checker.sv
`timescale 1ns / 1ps
// Checker for the stack push/pop bus sequencer: predicts bus state per word and compares.
module sppb_bus_checker import sppb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// tdata: opcode, sp_in, push_high, push_low, phase, ready_req, data_in, zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: mode
	input  logic [0:0]            s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata: address, address_driven, data_out, data_driven, sync, dbin, write_n,
	//        wait_flag, sp_out, pop_high, pop_low, zero fill
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	// tlast: done_res
	input  logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]            cfg_data,
	output int                    fails,
	output int                    pending,
	output int                    checked
);

	// Predicted sequencer state
	step_t       seq;
	logic        is_pop;
	logic [1:0]  pair;
	logic [15:0] sp, alatch, baddr;
	logic [7:0]  hold_hi, hold_lo, bdata;
	logic        a_on, d_on, sync_l, dbin_l, wrn_l, wait_l;
	logic [7:0]  stat_wr, stat_rd;

	result_t bus_state_q[$];
	int      n_fail = 0;
	int      n_checked = 0;

	// Advance the predicted sequencer by one input word, return the bus state after it
	function automatic result_t bus_cycle_step(input item_t w);
		result_t    r;
		logic [7:0] kind;
		logic       last_t3;
		last_t3 = 1'b0;
		if (w.mode == MODE_START) begin
			kind = w.opcode & OP_KIND_MASK;
			if (kind == OP_KIND_PUSH || kind == OP_KIND_POP) begin
				is_pop  = (kind == OP_KIND_POP);
				pair    = w.opcode[5:4];
				sp      = w.sp_in;
				hold_hi = is_pop ? 8'h00 : w.push_high;
				hold_lo = is_pop ? 8'h00 : w.push_low;
				seq     = is_pop ? ST_O_T4 : ST_U_T4;
			end
		end else begin
			last_t3 = (seq == ST_U_M3T3 || seq == ST_O_M3T3);
			case (w.phase)
			PH_ONE_RISE: begin
				if (seq == ST_U_M2T3 || seq == ST_U_M3T3) wrn_l = 1'b0;
				else if (seq == ST_O_M2TW || seq == ST_O_M3TW) wait_l = 1'b1;
				else if (seq == ST_O_M2T3 || seq == ST_O_M3T3) wait_l = 1'b0;
			end
			PH_TWO_RISE: begin
				case (seq)
				ST_U_T4: alatch = sp;
				ST_U_T5: sp = alatch - 16'd1;
				// T1 of a stack cycle: address out, status on the data bus
				ST_U_M2T1, ST_U_M3T1, ST_O_M2T1, ST_O_M3T1: begin
					alatch = sp;
					baddr  = sp;
					a_on   = 1'b1;
					d_on   = 1'b1;
					sync_l = 1'b1;
					bdata  = (seq == ST_O_M2T1 || seq == ST_O_M3T1) ? stat_rd : stat_wr;
				end
				ST_U_M2T2: begin
					sp     = alatch - 16'd1;
					sync_l = 1'b0;
					bdata  = hold_hi;
				end
				ST_U_M3T2: begin
					sync_l = 1'b0;
					bdata  = hold_lo;
				end
				ST_O_M2T2, ST_O_M3T2: begin
					d_on   = 1'b0;
					sync_l = 1'b0;
					dbin_l = 1'b1;
					sp     = alatch + 16'd1;
				end
				ST_O_M2TW, ST_O_M3TW: dbin_l = 1'b1;
				// low byte first; PSW flags get the fixed bits
				ST_O_M2T3: begin
					hold_lo = (pair == PAIR_PSW) ? ((w.data_in | PSW_SET) & ~PSW_CLR)
						: w.data_in;
					dbin_l  = 1'b0;
					a_on    = 1'b0;
				end
				ST_O_M3T3: begin
					hold_hi = w.data_in;
					dbin_l  = 1'b0;
					a_on    = 1'b0;
				end
				default: ;
				endcase
			end
			PH_TWO_FALL: begin
				case (seq)
				ST_U_M2T3, ST_U_M3T3: begin
					wrn_l = 1'b1;
					a_on  = 1'b0;
					seq   = (seq == ST_U_M3T3) ? ST_IDLE : ST_U_M3T1;
				end
				ST_O_M2T2, ST_O_M2TW: seq = w.ready_req ? ST_O_M2T3 : ST_O_M2TW;
				ST_O_M3T2, ST_O_M3TW: seq = w.ready_req ? ST_O_M3T3 : ST_O_M3TW;
				ST_O_M2T3: seq = ST_O_M3T1;
				ST_O_M3T3: seq = ST_IDLE;
				ST_IDLE: ;
				default: seq = step_t'(seq + 5'd1);
				endcase
			end
			default: ;
			endcase
		end
		r.address        = a_on ? baddr : 16'h0000;
		r.address_driven = a_on;
		r.data_out       = d_on ? bdata : 8'h00;
		r.data_driven    = d_on;
		r.sync           = sync_l;
		r.dbin           = dbin_l;
		r.write_n        = wrn_l;
		r.wait_flag      = wait_l;
		r.done_res       = last_t3;
		r.sp_out         = sp;
		r.pop_high       = is_pop ? hold_hi : 8'h00;
		r.pop_low        = is_pop ? hold_lo : 8'h00;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			n_fail++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t   w;
		result_t want;
		if (!arst_n) begin
			seq     = ST_IDLE;
			is_pop  = 1'b0;
			pair    = 2'd0;
			sp      = 16'h0000;
			alatch  = 16'h0000;
			baddr   = 16'h0000;
			hold_hi = 8'h00;
			hold_lo = 8'h00;
			bdata   = 8'h00;
			a_on    = 1'b0;
			d_on    = 1'b0;
			sync_l  = 1'b0;
			dbin_l  = 1'b0;
			wrn_l   = 1'b1;
			wait_l  = 1'b0;
			stat_wr = STATUS_WRITE_RST;
			stat_rd = STATUS_READ_RST;
			bus_state_q.delete();
		end else begin
			// result side first: a word queued at this edge cannot be due yet
			if (m_axis_tvalid && m_axis_tready) begin
				if (bus_state_q.size() == 0) begin
					$display("%0t ns: result word %h (last %b) with nothing expected",
						$time, m_axis_tdata, m_axis_tlast);
					n_fail++;
				end else begin
					want = bus_state_q.pop_front();
					check_field("address", want.address, m_axis_tdata[15:0]);
					check_field("address_driven", 16'(want.address_driven),
						16'(m_axis_tdata[16]));
					check_field("data_out", 16'(want.data_out), 16'(m_axis_tdata[24:17]));
					check_field("data_driven", 16'(want.data_driven), 16'(m_axis_tdata[25]));
					check_field("sync", 16'(want.sync), 16'(m_axis_tdata[26]));
					check_field("dbin", 16'(want.dbin), 16'(m_axis_tdata[27]));
					check_field("write_n", 16'(want.write_n), 16'(m_axis_tdata[28]));
					check_field("wait_flag", 16'(want.wait_flag), 16'(m_axis_tdata[29]));
					check_field("sp_out", want.sp_out, m_axis_tdata[45:30]);
					check_field("pop_high", 16'(want.pop_high), 16'(m_axis_tdata[53:46]));
					check_field("pop_low", 16'(want.pop_low), 16'(m_axis_tdata[61:54]));
					check_field("done_res", 16'(want.done_res), 16'(m_axis_tlast));
					n_checked++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				w.mode      = s_axis_tuser[0];
				w.opcode    = s_axis_tdata[7:0];
				w.sp_in     = s_axis_tdata[23:8];
				w.push_high = s_axis_tdata[31:24];
				w.push_low  = s_axis_tdata[39:32];
				w.phase     = s_axis_tdata[41:40];
				w.ready_req = s_axis_tdata[42];
				w.data_in   = s_axis_tdata[50:43];
				bus_state_q.push_back(bus_cycle_step(w));
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_STATUS_WRITE) stat_wr = cfg_data;
				else if (cfg_index == CFG_STATUS_READ) stat_rd = cfg_data;
			end
		end
		pending <= bus_state_q.size();
		fails   <= n_fail;
		checked <= n_checked;
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus and verdict for the stack push/pop bus sequencer.
module tb_top;
	import sppb_pkg::*;

	localparam logic       MODE_EVENT   = ~MODE_START;
	localparam logic [1:0] PH_NONE      = 2'd3;    // unused phase code, the block ignores it
	localparam int         LATENCY      = 2;
	localparam int         LIMIT_CYCLES = 200000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// tdata: opcode, sp_in, push_high, push_low, phase, ready_req, data_in, zero fill
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	// tuser: mode
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// tdata: address, address_driven, data_out, data_driven, sync, dbin, write_n,
	//        wait_flag, sp_out, pop_high, pop_low, zero fill
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// tlast: done_res
	logic                  m_axis_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [7:0]            cfg_data;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int n_items = 0;
	int n_noise = 0;
	int n_cfg = 0;
	int cycles = 0;
	int fails, pending, checked;

	stack_push_pop_bus_sequencer_unit u_top (.*);

	sppb_bus_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fails         (fails),
		.pending       (pending),
		.checked       (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result side back-pressure
	always @(posedge clk) begin
		m_axis_tready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic logic [7:0] stack_op(input logic pop, input logic [1:0] pair);
		return (pop ? OP_KIND_POP : OP_KIND_PUSH) | {2'b00, pair, 4'b0000};
	endfunction

	task automatic send_item(input item_t w);
		// random gap before the word
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= w.mode;
		s_axis_tdata  <= {w.data_in, w.ready_req, w.phase, w.push_low, w.push_high,
			w.sp_in, w.opcode};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		n_items++;
	endtask

	// Unused fields of each word carry random bits
	task automatic send_start(input logic [7:0] op, input logic [15:0] sp_val,
		input logic [7:0] hi, input logic [7:0] lo);
		item_t       w;
		logic [63:0] r;
		r           = {$urandom, $urandom};
		w           = r[$bits(item_t)-1:0];
		w.mode      = MODE_START;
		w.opcode    = op;
		w.sp_in     = sp_val;
		w.push_high = hi;
		w.push_low  = lo;
		send_item(w);
	endtask

	task automatic send_event(input logic [1:0] ph, input logic rdy, input logic [7:0] din);
		item_t       w;
		logic [63:0] r;
		r           = {$urandom, $urandom};
		w           = r[$bits(item_t)-1:0];
		w.mode      = MODE_EVENT;
		w.phase     = ph;
		w.ready_req = rdy;
		w.data_in   = din;
		send_item(w);
	endtask

	// One T state: phase one rise, phase two rise, phase two fall
	task automatic run_tstate(input logic rdy);
		send_event(PH_ONE_RISE, 1'($urandom_range(1)), 8'($urandom));
		send_event(PH_TWO_RISE, 1'($urandom_range(1)), 8'($urandom));
		send_event(PH_TWO_FALL, rdy, 8'($urandom));
	endtask

	task automatic send_noise();
		item_t       w;
		logic [63:0] r;
		r = {$urandom, $urandom};
		w = r[$bits(item_t)-1:0];
		if ($urandom_range(2) == 0) begin
			w.mode  = MODE_EVENT;
			w.phase = PH_NONE;
		end
		n_noise++;
		send_item(w);
	endtask

	// Full PUSH or POP with random content; some are cut short by the next start
	task automatic run_sequence();
		logic        pop;
		logic [15:0] sp_val;
		int          n_states, cut, waits;
		pop = 1'($urandom_range(1));
		case ($urandom_range(7))
		0:       sp_val = 16'h0000;
		1:       sp_val = 16'hFFFF;
		2:       sp_val = 16'h0001;
		default: sp_val = 16'($urandom);
		endcase
		send_start(stack_op(pop, 2'($urandom_range(3))), sp_val, 8'($urandom),
			8'($urandom));
		n_states = pop ? 7 : 8;
		cut = ($urandom_range(7) == 0) ? $urandom_range(n_states - 1) : n_states;
		for (int k = 0; k < cut; k++) begin
			// pop T states 2 and 5 are the M2/M3 T2, where READY low inserts waits
			if (pop && (k == 2 || k == 5)) begin
				waits = ($urandom_range(2) == 0) ? $urandom_range(1, 4) : 0;
				run_tstate(waits == 0);
				for (int j = 1; j <= waits; j++) run_tstate(j == waits);
			end else begin
				run_tstate(1'($urandom_range(1)));
			end
		end
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input int n);
		int base;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		base = n_items - n_noise;
		while (n_items - n_noise - base < n) begin
			if ($urandom_range(9) < 8) run_sequence();
			else send_noise();
		end
	endtask

	// Hold the sender off until every expected word is back, plus the pipeline depth
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic reconfigure(input logic [7:0] sw, input logic [7:0] sr);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_STATUS_WRITE;
		cfg_data  <= sw;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_STATUS_READ;
		cfg_data  <= sr;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		n_cfg += 2;
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 12;
		rx_idle_pct = 73;
		// idle bus: a phase event with no sequence, then the unused phase code
		send_event(PH_TWO_FALL, 1'b1, 8'hFF);
		send_event(PH_NONE, 1'b0, 8'h00);
		// opcodes outside the push/pop family leave the sequencer state unchanged
		send_start(8'h00, 16'hFFFF, 8'hFF, 8'hFF);
		send_start(8'hFF, 16'h0000, 8'h00, 8'h00);
		// PUSH PSW from SP 0: T5 wraps SP to FFFF, then M2 T1 drives status
		send_start(stack_op(1'b0, PAIR_PSW), 16'h0000, 8'hFF, 8'hFF);
		send_event(PH_TWO_RISE, 1'b0, 8'h00);
		send_event(PH_TWO_FALL, 1'b1, 8'h00);
		send_event(PH_TWO_RISE, 1'b0, 8'h00);
		send_event(PH_TWO_FALL, 1'b1, 8'h00);
		send_event(PH_ONE_RISE, 1'b0, 8'h00);
		send_event(PH_TWO_RISE, 1'b1, 8'hFF);
		send_event(PH_NONE, 1'b1, 8'hFF);
		// POP PSW while the push is busy, SP FFFF, one wait state, flags byte read
		send_start(stack_op(1'b1, PAIR_PSW), 16'hFFFF, 8'h00, 8'h00);
		send_event(PH_TWO_FALL, 1'b1, 8'h00);
		send_event(PH_TWO_RISE, 1'b0, 8'h00);
		send_event(PH_TWO_FALL, 1'b1, 8'h00);
		send_event(PH_TWO_RISE, 1'b1, 8'h00);
		send_event(PH_TWO_FALL, 1'b0, 8'h00);
		send_event(PH_ONE_RISE, 1'b0, 8'h00);
		send_event(PH_TWO_RISE, 1'b0, 8'h00);
		send_event(PH_TWO_FALL, 1'b1, 8'h00);
		send_event(PH_ONE_RISE, 1'b1, 8'h00);
		send_event(PH_TWO_RISE, 1'b0, 8'hFF);
		send_event(PH_TWO_FALL, 1'b1, 8'h00);

		reconfigure(8'hFF, 8'h00);
		run_phase(12, 73, 250);
		reconfigure(8'h00, 8'hFF);
		run_phase(73, 12, 250);
		reconfigure(8'($urandom), 8'($urandom));
		run_phase(0, 0, 250);
		drain();

		$display("Sent %0d words (%0d noise) over three stall profiles, %0d register writes.",
			n_items, n_noise, n_cfg);
		$display("Checked %0d result words against the predicted bus state.", checked);
		if (fails == 0 && pending == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/sppb_pkg.sv
rtl/sppb_step.sv
rtl/stack_push_pop_bus_sequencer_unit.sv
tb/sppb_bus_checker.sv
tb/tb_top.sv
